// ===== hw/rtl/mtcd_pkg.sv =====
// ----------------------------------------------------------------------------
// mtcd_pkg
// Shared types and constants of the missing-tooth crank decoder.
// ----------------------------------------------------------------------------
package mtcd_pkg;

    // Default timestamp width
    localparam int TIME_BITS_DEF = 32;

    // Field widths fixed by the interface
    localparam int CAP_W   = 16;
    localparam int EXT_W   = 16;
    localparam int TEETH_W = 7;
    localparam int CNT_W   = 8;
    localparam int TICK_W  = 16;
    localparam int TOTAL_W = 16;

    // Present teeth per revolution after reset
    localparam logic [TEETH_W-1:0] TEETH_RESET = 7'd35;

    // Edge position that passes without a ratio check
    localparam logic [CNT_W-1:0] CNT_UNCHECKED = 8'd2;
    // Edge position right after the gap
    localparam logic [CNT_W-1:0] CNT_AFTER_GAP = 8'd1;
    localparam logic [CNT_W-1:0] CNT_NONE      = 8'd0;

    // One captured crank edge
    typedef struct packed {
        logic [CAP_W-1:0] capture_time;
        logic [EXT_W-1:0] extension_high;
        logic             overflow_pending;
        logic             pin_level;
    } item_t;

    // One decoder result
    typedef struct packed {
        logic               sync_flag;
        logic [TICK_W-1:0]  gap_tick_record;
        logic               edge_echo;
        logic [CNT_W-1:0]   edge_position;
        logic [TOTAL_W-1:0] teeth_seen;
    } result_t;

endpackage

// ===== hw/rtl/mtcd_timebase.sv =====
// ----------------------------------------------------------------------------
// mtcd_timebase
// Builds the extended timestamp of an edge and the period since the last one.
// ----------------------------------------------------------------------------
module mtcd_timebase
    import mtcd_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  item_t                item,
    input  logic [TIME_BITS-1:0] prev_stamp,
    output logic [TIME_BITS-1:0] stamp,
    output logic [TIME_BITS-1:0] period
);

    localparam logic [TIME_BITS-1:0] TIME_ONE = {{(TIME_BITS-1){1'b0}}, 1'b1};

    logic [EXT_W-1:0]       high_word;
    logic [EXT_W+CAP_W-1:0] full_stamp;

    // Count a pending overflow only when the capture was taken after it
    always_comb
    begin
        if (item.overflow_pending && !item.capture_time[CAP_W-1])
        begin
            high_word = item.extension_high + {{(EXT_W-1){1'b0}}, 1'b1};
        end
        else
        begin
            high_word = item.extension_high;
        end
        full_stamp = {high_word, item.capture_time};
    end

    assign stamp = full_stamp[TIME_BITS-1:0];

    // Plain difference, or one less when the stamp did not move forward
    always_comb
    begin
        if (stamp > prev_stamp)
        begin
            period = stamp - prev_stamp;
        end
        else
        begin
            period = stamp - prev_stamp - TIME_ONE;
        end
    end

endmodule

// ===== hw/rtl/mtcd_decoder.sv =====
// ----------------------------------------------------------------------------
// mtcd_decoder
// Tooth ratio checks, gap detection and the decoder state registers.
// ----------------------------------------------------------------------------
module mtcd_decoder
    import mtcd_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 pin_level,
    input  logic [TEETH_W-1:0]   real_teeth,
    input  logic [TIME_BITS-1:0] stamp,
    input  logic [TIME_BITS-1:0] period,
    output logic [TIME_BITS-1:0] prev_stamp,
    output result_t              result_next
);

    logic [TIME_BITS-1:0] prev_stamp_reg, prev_stamp_next;
    logic [TIME_BITS-1:0] prev_period_reg, prev_period_next;
    logic [TIME_BITS-1:0] low_dur_reg, low_dur_next;
    logic [TIME_BITS-1:0] tooth_reg, tooth_next;
    logic [TIME_BITS-1:0] last_gap_reg, last_gap_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 sync_reg, sync_next;
    logic [TICK_W-1:0]    ticks_reg, ticks_next;
    logic                 echo_reg, echo_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;

    logic [TIME_BITS-1:0] high_low;
    logic [TIME_BITS-1:0] p_half;
    logic [TIME_BITS-1:0] p_dbl;
    logic [TIME_BITS-1:0] gap_lo;
    logic [TIME_BITS-1:0] gap_up;
    logic [TIME_BITS-1:0] between;
    logic [CNT_W-1:0]     gap_at;
    logic                 at_gap;
    logic                 gap_hit;
    logic                 tooth_ok;

    assign prev_stamp = prev_stamp_reg;

    // Tooth time and ratio windows against the previous tooth
    always_comb
    begin
        high_low = period + low_dur_reg;
        p_half   = tooth_reg >> 1;
        p_dbl    = tooth_reg << 1;
        gap_lo   = tooth_reg + p_half;
        gap_up   = p_dbl + p_half;
        between  = stamp - last_gap_reg;
        gap_at   = {real_teeth, 1'b0};
        at_gap   = (cnt_reg == CNT_NONE) || (cnt_reg == gap_at);
        gap_hit  = (high_low > gap_lo) && (high_low < gap_up);
        tooth_ok = (cnt_reg == CNT_UNCHECKED) ||
                   (!cnt_reg[0] && (high_low > p_half) && (high_low < p_dbl));
    end

    // Next state for one edge
    always_comb
    begin
        prev_stamp_next  = stamp;
        prev_period_next = period;
        low_dur_next     = low_dur_reg;
        tooth_next       = tooth_reg;
        last_gap_next    = last_gap_reg;
        cnt_next         = cnt_reg;
        sync_next        = sync_reg;
        ticks_next       = ticks_reg;
        echo_next        = echo_reg;
        total_next       = total_reg + {{(TOTAL_W-1){1'b0}}, 1'b1};

        if (prev_period_reg != '0)
        begin
            if (pin_level)
            begin
                if (at_gap)
                begin
                    if (gap_hit)
                    begin
                        last_gap_next = stamp;
                        ticks_next    = between[TICK_W-1:0];
                        sync_next     = 1'b1;
                        cnt_next      = CNT_AFTER_GAP;
                    end
                    else
                    begin
                        sync_next = 1'b0;
                        cnt_next  = CNT_NONE;
                    end
                end
                else if (tooth_ok)
                begin
                    cnt_next = cnt_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                end
                else
                begin
                    sync_next = 1'b0;
                    cnt_next  = CNT_NONE;
                end
                echo_next  = 1'b1;
                tooth_next = high_low;
            end
            else
            begin
                // Falling edge must follow a rising one
                if (cnt_reg[0])
                begin
                    cnt_next = cnt_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                end
                else
                begin
                    sync_next = 1'b0;
                    cnt_next  = CNT_NONE;
                end
                echo_next    = 1'b0;
                low_dur_next = period;
            end
        end
    end

    // Result as seen after the update
    always_comb
    begin
        result_next.sync_flag       = sync_next;
        result_next.gap_tick_record = ticks_next;
        result_next.edge_echo       = echo_next;
        result_next.edge_position   = cnt_next;
        result_next.teeth_seen      = total_next;
    end

    // Commit state when an item moves through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_stamp_reg  <= '0;
            prev_period_reg <= '0;
            low_dur_reg     <= '0;
            tooth_reg       <= '0;
            last_gap_reg    <= '0;
            cnt_reg         <= '0;
            sync_reg        <= 1'b0;
            ticks_reg       <= '0;
            echo_reg        <= 1'b0;
            total_reg       <= '0;
        end
        else if (step)
        begin
            prev_stamp_reg  <= prev_stamp_next;
            prev_period_reg <= prev_period_next;
            low_dur_reg     <= low_dur_next;
            tooth_reg       <= tooth_next;
            last_gap_reg    <= last_gap_next;
            cnt_reg         <= cnt_next;
            sync_reg        <= sync_next;
            ticks_reg       <= ticks_next;
            echo_reg        <= echo_next;
            total_reg       <= total_next;
        end
    end

endmodule

// ===== hw/rtl/missing_tooth_crank_decoder.sv =====
// ----------------------------------------------------------------------------
// missing_tooth_crank_decoder
// Crank-only decoder for a missing-tooth wheel: one captured edge in, one
// sync and position result out.
// ----------------------------------------------------------------------------
// Accepts one edge item per clock and returns one result item for each: the
// edge lands in an input register, a single pass of add and compare logic
// (timestamp, period, tooth ratio windows) updates the decoder state, and the
// result goes to an output register. The throughput is set by that single
// state-update pass; it holds at one item per cycle for as long as out_ready
// is high. real_teeth (cfg_we/cfg_wdata) resets to 35; the user must write it
// only while no item is in flight, which the block does not enforce.
module missing_tooth_crank_decoder
    import mtcd_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_we,
    input  logic [TEETH_W-1:0]  cfg_wdata,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CAP_W-1:0]    capture_time,
    input  logic [EXT_W-1:0]    extension_high,
    input  logic                overflow_pending,
    input  logic                pin_level,

    output logic                out_valid,
    input  logic                out_ready,
    output logic                sync_flag,
    output logic [TICK_W-1:0]   gap_tick_record,
    output logic                edge_echo,
    output logic [CNT_W-1:0]    edge_position,
    output logic [TOTAL_W-1:0]  teeth_seen
);

    logic [TEETH_W-1:0]   teeth_reg;
    logic                 in_vld_reg;
    item_t                item_reg;
    logic                 out_vld_reg;
    result_t              res_reg;
    logic                 advance;
    logic                 take_in;
    logic [TIME_BITS-1:0] stamp;
    logic [TIME_BITS-1:0] period;
    logic [TIME_BITS-1:0] prev_stamp;
    result_t              result_next;

    // Move the held item on when the result register is free or draining
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;
    assign take_in  = in_valid && in_ready;

    // Hold the tooth count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            teeth_reg <= TEETH_RESET;
        end
        else if (cfg_we)
        begin
            teeth_reg <= cfg_wdata;
        end
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (take_in)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            item_reg.capture_time     <= capture_time;
            item_reg.extension_high   <= extension_high;
            item_reg.overflow_pending <= overflow_pending;
            item_reg.pin_level        <= pin_level;
        end
    end

    mtcd_timebase #(
        .TIME_BITS (TIME_BITS)
    ) u_timebase (
        .item       (item_reg),
        .prev_stamp (prev_stamp),
        .stamp      (stamp),
        .period     (period)
    );

    mtcd_decoder #(
        .TIME_BITS (TIME_BITS)
    ) u_decoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .pin_level   (item_reg.pin_level),
        .real_teeth  (teeth_reg),
        .stamp       (stamp),
        .period      (period),
        .prev_stamp  (prev_stamp),
        .result_next (result_next)
    );

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result_next;
        end
    end

    assign out_valid       = out_vld_reg;
    assign sync_flag       = res_reg.sync_flag;
    assign gap_tick_record = res_reg.gap_tick_record;
    assign edge_echo       = res_reg.edge_echo;
    assign edge_position   = res_reg.edge_position;
    assign teeth_seen      = res_reg.teeth_seen;

    // Without sync the position stays at zero
    a_nosync_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !sync_flag) |-> (edge_position == CNT_NONE))
        else $error("edge position nonzero without sync");

    // After a falling edge the position is even
    a_fall_even: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !edge_echo) |-> !edge_position[0])
        else $error("odd edge position after falling edge");

    // After a rising edge the position is odd or cleared
    a_rise_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && edge_echo && (edge_position != CNT_NONE)) |-> edge_position[0])
        else $error("even edge position after rising edge");

    // A held item reaches an empty result register in the next cycle
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !out_vld_reg) |=> out_vld_reg)
        else $error("held item did not reach the result register");

endmodule

// ===== verif/mtcd_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mtcd_checker
// Watches the crank decoder's channels, predicts each result and compares.
// ----------------------------------------------------------------------------
// Every accepted edge item runs through a cycle-free copy of the decoder
// (timestamp build, period, tooth ratio windows, gap search) and its result
// is queued. Every accepted result item is checked field by field against the
// oldest queued one. Configuration writes are tracked from the port itself.
module mtcd_checker
    import mtcd_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_we,
    input  logic [TEETH_W-1:0]  cfg_wdata,

    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [CAP_W-1:0]    capture_time,
    input  logic [EXT_W-1:0]    extension_high,
    input  logic                overflow_pending,
    input  logic                pin_level,

    input  logic                out_valid,
    input  logic                out_ready,
    input  logic                sync_flag,
    input  logic [TICK_W-1:0]   gap_tick_record,
    input  logic                edge_echo,
    input  logic [CNT_W-1:0]    edge_position,
    input  logic [TOTAL_W-1:0]  teeth_seen,

    output int                  fail_count,
    output int                  pending,
    output int                  results_checked,
    output int                  sync_gains
);

    localparam logic [31:0] STAMP_MASK = 32'hFFFF_FFFF >> (32 - TIME_BITS);

    // Predicted decoder state
    logic [TEETH_W-1:0] teeth_cfg;
    logic [31:0]        stamp_last;
    logic [31:0]        span_last;
    logic [31:0]        high_span;
    logic [31:0]        tooth_last;
    logic [31:0]        gap_stamp;
    logic [CNT_W-1:0]   position;
    logic               locked;
    logic [TICK_W-1:0]  tick_record;
    logic               echo_level;
    logic [TOTAL_W-1:0] edge_tally;

    result_t expected_results[$];

    // Advance the predicted decoder by one crank edge and return its result
    function automatic result_t decode_edge(input item_t e);
        logic [EXT_W-1:0] hi_word;
        logic [31:0]      stamp;
        logic [31:0]      span;
        logic [31:0]      tooth;
        logic [31:0]      prev;
        logic [31:0]      lo_lim;
        logic [31:0]      hi_lim;
        logic [31:0]      between;
        logic [CNT_W-1:0] gap_pos;
        result_t          r;

        // Fold a pending overflow into the high word
        hi_word = (e.overflow_pending && !e.capture_time[CAP_W-1]) ?
                  e.extension_high + 16'd1 : e.extension_high;
        stamp = {hi_word, e.capture_time} & STAMP_MASK;

        if (stamp > stamp_last)
            span = (stamp - stamp_last) & STAMP_MASK;
        else
            span = (stamp + (STAMP_MASK - stamp_last)) & STAMP_MASK;
        stamp_last = stamp;

        // Decode only once a nonzero previous period exists
        if (span_last != 0) begin
            if (e.pin_level) begin
                tooth = (span + high_span) & STAMP_MASK;
                prev = tooth_last;
                gap_pos = {teeth_cfg, 1'b0};
                if (position == CNT_NONE || position == gap_pos) begin
                    lo_lim = (prev + (prev >> 1)) & STAMP_MASK;
                    hi_lim = ((prev << 1) + (prev >> 1)) & STAMP_MASK;
                    if (tooth > lo_lim && tooth < hi_lim) begin
                        between = (stamp - gap_stamp) & STAMP_MASK;
                        gap_stamp = stamp;
                        tick_record = between[TICK_W-1:0];
                        locked = 1'b1;
                        position = CNT_AFTER_GAP;
                        sync_gains++;
                    end
                    else begin
                        locked = 1'b0;
                        position = CNT_NONE;
                    end
                end
                else if (position == CNT_UNCHECKED ||
                         (!position[0] && tooth > (prev >> 1) &&
                          tooth < ((prev << 1) & STAMP_MASK))) begin
                    position = position + 8'd1;
                end
                else begin
                    locked = 1'b0;
                    position = CNT_NONE;
                end
                echo_level = 1'b1;
                tooth_last = tooth;
            end
            else begin
                // Falling edges belong at odd positions only
                if (position[0]) begin
                    position = position + 8'd1;
                end
                else begin
                    locked = 1'b0;
                    position = CNT_NONE;
                end
                echo_level = 1'b0;
                high_span = span;
            end
        end
        span_last = span;
        edge_tally = edge_tally + 16'd1;

        r.sync_flag       = locked;
        r.gap_tick_record = tick_record;
        r.edge_echo       = echo_level;
        r.edge_position   = position;
        r.teeth_seen      = edge_tally;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            fail_count++;
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    // Track config, check results, then queue predictions for new items
    always @(posedge clk or negedge rst_n) begin : watch
        result_t want;
        item_t   taken;

        if (!rst_n) begin
            teeth_cfg       = TEETH_RESET;
            stamp_last      = '0;
            span_last       = '0;
            high_span       = '0;
            tooth_last      = '0;
            gap_stamp       = '0;
            position        = CNT_NONE;
            locked          = 1'b0;
            tick_record     = '0;
            echo_level      = 1'b0;
            edge_tally      = '0;
            fail_count      = 0;
            pending         = 0;
            results_checked = 0;
            sync_gains      = 0;
            expected_results.delete();
        end
        else begin
            if (cfg_we)
                teeth_cfg = cfg_wdata;

            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $error("result item with no edge item waiting");
                end
                else begin
                    want = expected_results.pop_front();
                    check_field("sync_flag", 32'(want.sync_flag), 32'(sync_flag));
                    check_field("gap_tick_record", 32'(want.gap_tick_record),
                                32'(gap_tick_record));
                    check_field("edge_echo", 32'(want.edge_echo), 32'(edge_echo));
                    check_field("edge_position", 32'(want.edge_position),
                                32'(edge_position));
                    check_field("teeth_seen", 32'(want.teeth_seen), 32'(teeth_seen));
                    results_checked++;
                end
            end

            if (in_valid && in_ready) begin
                taken.capture_time     = capture_time;
                taken.extension_high   = extension_high;
                taken.overflow_pending = overflow_pending;
                taken.pin_level        = pin_level;
                expected_results.push_back(decode_edge(taken));
            end

            pending = expected_results.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the missing-tooth crank decoder.
// ----------------------------------------------------------------------------
// Drives timestamp corner cases first, then simulated crank wheels of many
// speeds and tooth counts, mixed with broken teeth, lone edges, gap ratios on
// the window limits, time jumps and random noise. The sender works in bursts,
// the receiver stalls on its own schedule and once holds off for a long time.
// The checker beside the block predicts and compares every result.
module tb;
    import mtcd_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int PLAN_LEN     = 8;

    localparam logic PIN_RISE = 1'b1;
    localparam logic PIN_FALL = 1'b0;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [TEETH_W-1:0] cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic [CAP_W-1:0]   capture_time;
    logic [EXT_W-1:0]   extension_high;
    logic               overflow_pending;
    logic               pin_level;
    logic               out_valid;
    logic               out_ready;
    logic               sync_flag;
    logic [TICK_W-1:0]  gap_tick_record;
    logic               edge_echo;
    logic [CNT_W-1:0]   edge_position;
    logic [TOTAL_W-1:0] teeth_seen;

    int fail_count;
    int pending;
    int results_checked;
    int sync_gains;

    // Wheel model and sender bookkeeping
    logic [31:0] wheel_now;
    int unsigned burst_left;
    int          edges_sent;
    int          settings_used;
    logic        hold_req;
    logic        hold_done;

    missing_tooth_crank_decoder dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .capture_time     (capture_time),
        .extension_high   (extension_high),
        .overflow_pending (overflow_pending),
        .pin_level        (pin_level),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .sync_flag        (sync_flag),
        .gap_tick_record  (gap_tick_record),
        .edge_echo        (edge_echo),
        .edge_position    (edge_position),
        .teeth_seen       (teeth_seen)
    );

    mtcd_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offer one edge item and hold it until accepted; idle between bursts
    task automatic send_edge(input logic [CAP_W-1:0] cap, input logic [EXT_W-1:0] ext,
                             input logic ovf, input logic pin);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                                                      $urandom_range(1, 30);
        end
        in_valid         <= 1'b1;
        capture_time     <= cap;
        extension_high   <= ext;
        overflow_pending <= ovf;
        pin_level        <= pin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        burst_left--;
        edges_sent++;
    endtask

    // Capture the wheel time, encoding the high word in any consistent way
    task automatic stamp_edge(input logic pin);
        logic [CAP_W-1:0] cap;
        logic [EXT_W-1:0] ext;
        logic             ovf;
        cap = wheel_now[15:0];
        ext = wheel_now[31:16];
        ovf = 1'b0;
        case ($urandom_range(0, 2))
            0: if (!cap[CAP_W-1]) begin
                ext = ext - 16'd1;
                ovf = 1'b1;
            end
            1: if (cap[CAP_W-1]) ovf = 1'b1;
            default: ;
        endcase
        send_edge(cap, ext, ovf, pin);
    endtask

    // One tooth: low stretch (longer by extra over the gap), then high stretch
    task automatic crank_tooth(input int unsigned t, input int unsigned extra);
        wheel_now = wheel_now + t / 2 + extra;
        stamp_edge(PIN_RISE);
        wheel_now = wheel_now + (t - t / 2);
        stamp_edge(PIN_FALL);
    endtask

    function automatic int unsigned jitter(input int unsigned t);
        longint unsigned scaled;
        scaled = t;
        scaled = scaled * $urandom_range(94, 106) / 100;
        return (scaled == 0) ? 1 : 32'(scaled);
    endfunction

    // One revolution, starting with the tooth after the missing one
    task automatic crank_rev(input int n, input int unsigned t);
        for (int k = 0; k < n; k++)
            crank_tooth(jitter(t), (k == 0) ? jitter(t) : 0);
    endtask

    function automatic int unsigned pick_tooth();
        case ($urandom_range(0, 19))
            0:       return $urandom_range(32'h0100_0000, 32'h8000_0000);
            1, 2:    return $urandom_range(10000, 300000);
            default: return $urandom_range(16, 8000);
        endcase
    endfunction

    // Drop valid and wait until every result is back and the pipe is empty
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_teeth(input logic [TEETH_W-1:0] value);
        settle_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    // Stimulus
    initial
    begin
        int unsigned t;
        int unsigned te;
        int          pick;
        int          ph_end;
        int          teeth_plan[PLAN_LEN];
        int          phase_budget[PLAN_LEN];

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        in_valid         = 1'b0;
        capture_time     = '0;
        extension_high   = '0;
        overflow_pending = 1'b0;
        pin_level        = 1'b0;
        hold_req         = 1'b0;
        burst_left       = 0;
        edges_sent       = 0;
        settings_used    = 0;
        wheel_now        = $urandom;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Timestamp corners: equal stamps, zero period, high word wrap
        send_edge(16'h0000, 16'h0000, 1'b0, PIN_RISE);
        send_edge(16'hFFFF, 16'hFFFF, 1'b0, PIN_FALL);
        send_edge(16'h0000, 16'h0000, 1'b0, PIN_RISE);
        send_edge(16'h1234, 16'h0001, 1'b0, PIN_RISE);
        send_edge(16'h7FFF, 16'hFFFF, 1'b1, PIN_FALL);
        send_edge(16'h8000, 16'hFFFF, 1'b1, PIN_RISE);
        send_edge(16'h8000, 16'hFFFF, 1'b1, PIN_RISE);

        // Gap position equal to the unchecked position: gap search must win
        write_teeth(7'd1);
        wheel_now = 32'hFFFF_FF00;
        repeat (3) crank_tooth(200, 0);
        crank_tooth(200, 200);
        crank_tooth(200, 0);
        crank_tooth(200, 200);
        crank_tooth(200, 200);

        // Gain sync on a long wheel, then cut the tooth count so the position wraps
        write_teeth(7'd127);
        t = $urandom_range(100, 5000);
        repeat (2) crank_tooth(jitter(t), 0);
        crank_tooth(jitter(t), jitter(t));
        repeat (60) crank_tooth(jitter(t), 0);
        write_teeth(7'd3);
        repeat (70) crank_tooth(jitter(t), 0);

        // Random wheels per tooth-count setting
        teeth_plan   = '{3, 127, 0, 2, 35, 1, 0, 0};
        teeth_plan[6] = $urandom_range(4, 126);
        teeth_plan[7] = $urandom_range(4, 126);
        phase_budget = '{150, 380, 120, 120, 160, 120, 110, 110};
        hold_req = 1'b1;
        for (int i = 0; i < PLAN_LEN; i++) begin
            write_teeth(7'(teeth_plan[i]));
            ph_end = edges_sent + phase_budget[i];
            while (edges_sent < ph_end) begin
                pick = $urandom_range(0, 99);
                t = pick_tooth();
                if (pick < 70) begin
                    crank_rev((teeth_plan[i] == 0) ? 1 : teeth_plan[i], t);
                end
                else if (pick < 80) begin
                    send_edge(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                end
                else if (pick < 88) begin
                    // Tooth far outside the ratio window
                    crank_tooth((t < 32'h4000_0000) ? 4 * t : t / 4 + 2, 0);
                end
                else if (pick < 93) begin
                    // Lone edge, possibly repeating the last polarity
                    wheel_now = wheel_now + jitter(t) / 2;
                    stamp_edge(1'($urandom_range(0, 1)));
                end
                else if (pick < 97) begin
                    // Gap tooth on or just inside the window limits
                    te = $urandom_range(50, 2500) * 2;
                    crank_tooth(te, 0);
                    crank_tooth(te, 0);
                    case ($urandom_range(0, 3))
                        0:       crank_tooth(te, te / 2);
                        1:       crank_tooth(te, te / 2 + 1);
                        2:       crank_tooth(te, 3 * te / 2);
                        default: crank_tooth(te, 3 * te / 2 - 1);
                    endcase
                end
                else begin
                    wheel_now = $urandom;
                end
            end
        end

        settle_idle();
        $display("Covered %0d crank edges over %0d tooth-count settings; %0d results checked.",
                 edges_sent, settings_used, results_checked);
        $display("Sync was gained %0d times; one output stall of %0d cycles applied.",
                 sync_gains, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Receiver: random stall segments, plus one long hold-off
    initial
    begin
        int seg;
        int mode;
        int beat;
        out_ready = 1'b0;
        hold_done = 1'b0;
        beat = 0;
        @(posedge rst_n);
        forever begin
            seg  = $urandom_range(20, 200);
            mode = $urandom_range(0, 3);
            repeat (seg) begin
                @(negedge clk);
                if (hold_req && !hold_done) begin
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    hold_done = 1'b1;
                end
                else begin
                    case (mode)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= 1'($urandom_range(0, 1));
                        2:       out_ready <= ((beat % 3) != 0);
                        default: out_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                end
                beat++;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule
